// ----- rtl/core/conv3x3_rgb_clamp_filter_defines.svh -----
// Assertion macros shared by the filter RTL.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef CONV3X3_RGB_CLAMP_FILTER_DEFINES_SVH
`define CONV3X3_RGB_CLAMP_FILTER_DEFINES_SVH

// Same-cycle implication.
`define C3F_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("filter assertion failed");

// Next-cycle implication.
`define C3F_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("filter assertion failed");

`endif

// ----- rtl/core/c3f_pkg.sv -----
// Types and constants of the 3x3 RGB convolution filter.
// No dependencies.
package c3f_pkg;
	localparam int TAP_W  = 12;
	localparam int PROD_W = 21;
	localparam int PART_W = 22;
	localparam int SUM_W  = 24;
	localparam int CFG_W  = 60;
	localparam int NUM_TAPS = 9;
	localparam logic [7:0] CH_MAX = 8'd255;
	localparam logic [7:0] CH_MIN = 8'd0;
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		REG_TAPS_LOW  = 2'd0,
		REG_TAPS_HIGH = 2'd1,
		REG_WIDTH     = 2'd2,
		REG_HEIGHT    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	typedef struct packed {
		rgba_t top;
		rgba_t mid;
		rgba_t bot;
	} column_t;

	typedef struct packed {
		logic       op;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic       shift;
		logic       adv;
		logic [2:0] row_ok;
		logic       col_ok;
	} cell_ctrl_t;

	typedef logic signed [TAP_W-1:0]  tap_t;
	typedef logic signed [PART_W-1:0] part_t;
endpackage

// ----- rtl/core/c3f_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Payload types come from c3f_pkg.
interface c3f_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/conv3x3_rgb_clamp_filter.sv -----
// 3x3 RGB convolution filter, zero padded, results clamped to 0..255.
// Throughput: one beat per cycle while the output is not stalled; the line store has one read and one write port.
// Each result passes registers s1 to s4 after the beat that completes its window,
// which comes image_width+1 beats after its center pixel.
// Reset clears control, positions and window; line store contents stay undefined.
// Depends on c3f_pkg, c3f_stream_if, c3f_line_buf, c3f_cell.
`include "conv3x3_rgb_clamp_filter_defines.svh"
module conv3x3_rgb_clamp_filter #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [c3f_pkg::CFG_W-1:0]     cfg_data,
	c3f_stream_if.sink                    pixels,
	c3f_stream_if.source                  filtered
);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [59:0]   taps_lo_q;
	logic [47:0]   taps_hi_q;
	logic [CW-1:0] width_q, in_col_q, out_col_q;
	logic [RW-1:0] height_q, in_row_q, out_row_q;

	logic en, acc, intake, proceed, emit_c, last_c;
	logic [12:0] size_v;
	logic [CW-1:0] width_clip, in_col_inc;
	logic [RW-1:0] height_clip, in_row_inc;
	c3f_pkg::rgba_t pix;

	logic v_s1, emit_s1, last_s1, v_s2, last_s2, v_s3, last_s3, v_s4;
	logic [2:0] rowok_s1, colok_s1, rowok_s2, colok_s2;
	logic [7:0] alpha_s3;
	c3f_pkg::out_item_t out_s4, out_d;

	c3f_pkg::column_t col_s1;
	c3f_pkg::column_t col_q [3];
	c3f_pkg::part_t [2:0] part_s3 [3];
	c3f_pkg::tap_t all_taps [c3f_pkg::NUM_TAPS];

	assign en = !v_s4 || filtered.ready;
	assign pixels.ready = en;
	assign acc = pixels.valid && en;
	assign intake = in_row_q < height_q;
	// A drain beat during intake is dropped without a trace.
	assign proceed = acc && !(pixels.data.op == c3f_pkg::OP_DRAIN && intake);
	assign pix = intake ? {pixels.data.in_alpha, pixels.data.in_blue,
		pixels.data.in_green, pixels.data.in_red} : '0;
	assign emit_c = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
	assign last_c = (out_row_q == height_q - RW'(1)) && (out_col_q == width_q - CW'(1));
	assign in_col_inc = in_col_q + CW'(1);
	assign in_row_inc = in_row_q + RW'(1);

	assign size_v = cfg_data[12:0];
	assign width_clip = (size_v == '0) ? CW'(1) :
		(int'(size_v) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(size_v);
	assign height_clip = (size_v == '0) ? RW'(1) :
		(int'(size_v) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(size_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_lo_q <= 60'h010_0000_0000_0000;
			taps_hi_q <= '0;
			width_q   <= CW'(640);
			height_q  <= RW'(480);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (proceed) begin
				if (in_col_inc >= width_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_inc;
				end else begin
					in_col_q <= in_col_inc;
				end
				if (emit_c) begin
					if (out_col_q + CW'(1) >= width_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
					// Frame done: restart all positions.
					if (last_c) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
				end
			end
			if (cfg_we) begin
				case (c3f_pkg::reg_idx_t'(cfg_index))
					c3f_pkg::REG_TAPS_LOW: begin
						taps_lo_q <= cfg_data;
					end
					c3f_pkg::REG_TAPS_HIGH: begin
						taps_hi_q <= cfg_data[47:0];
					end
					c3f_pkg::REG_WIDTH: begin
						width_q   <= width_clip;
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					c3f_pkg::REG_HEIGHT: begin
						height_q  <= height_clip;
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Pipeline control; the whole chain holds while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= proceed;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emit_s1  <= emit_c;
			last_s1  <= last_c;
			rowok_s1 <= {out_row_q != height_q - RW'(1), 1'b1, out_row_q != '0};
			colok_s1 <= {out_col_q != width_q - CW'(1), 1'b1, out_col_q != '0};
			rowok_s2 <= rowok_s1;
			colok_s2 <= colok_s1;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
			alpha_s3 <= col_q[1].mid.alpha;
			out_s4   <= out_d;
		end
	end

	c3f_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (proceed),
		.rd_addr(in_col_q[AW-1:0]),
		.pix_in (pix),
		.wr_en  (en && v_s1),
		.col_s1 (col_s1)
	);

	always_comb begin
		for (int k = 0; k < c3f_pkg::NUM_TAPS; k++) begin
			if (k < 5) begin
				all_taps[k] = taps_lo_q[12*k +: 12];
			end else begin
				all_taps[k] = taps_hi_q[12*(k-5) +: 12];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_cell
		c3f_pkg::cell_ctrl_t ctrl;
		c3f_pkg::column_t feed;
		assign ctrl.shift  = en && v_s1;
		assign ctrl.adv    = en;
		assign ctrl.row_ok = rowok_s2;
		assign ctrl.col_ok = colok_s2[c];
		// New column enters on the right and moves left.
		assign feed = (c == 2) ? col_s1 : col_q[(c + 1) % 3];
		c3f_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.col_in (feed),
			.taps   ({all_taps[6 + c], all_taps[3 + c], all_taps[c]}),
			.col_q  (col_q[c]),
			.part_s3(part_s3[c])
		);
	end

	always_comb begin
		logic signed [c3f_pkg::SUM_W-1:0] sum;
		logic signed [c3f_pkg::SUM_W-1:0] q;
		logic [7:0] chv [3];
		sum = '0;
		q = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum = c3f_pkg::SUM_W'(part_s3[0][ch]) + c3f_pkg::SUM_W'(part_s3[1][ch])
				+ c3f_pkg::SUM_W'(part_s3[2][ch]);
			q = sum >>> COEF_FRAC_BITS;
			if (sum <= 0) begin
				chv[ch] = c3f_pkg::CH_MIN;
			end else if (q > $signed(c3f_pkg::SUM_W'(c3f_pkg::CH_MAX))) begin
				chv[ch] = c3f_pkg::CH_MAX;
			end else begin
				chv[ch] = q[7:0];
			end
		end
		out_d.out_red    = chv[0];
		out_d.out_green  = chv[1];
		out_d.out_blue   = chv[2];
		out_d.out_alpha  = alpha_s3;
		out_d.frame_last = last_s3;
	end

	assign filtered.valid = v_s4;
	assign filtered.data  = out_s4;

	`C3F_ASSERT_NEXT(a_frame_restart, proceed && emit_c && last_c && !cfg_we,
		in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
	`C3F_ASSERT_NOW(a_col_range, 1'b1, in_col_q < width_q && out_col_q < width_q)
	`C3F_ASSERT_NEXT(a_window_feed, en && v_s1 && emit_s1, v_s2)
endmodule

// ----- rtl/core/c3f_line_buf.sv -----
// Two-line pixel store with registered read and same-address forwarding.
// Depends on c3f_pkg.
module c3f_line_buf #(
	parameter int MAX_WIDTH = 4096,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	input  c3f_pkg::rgba_t           pix_in,
	input  logic                     wr_en,
	output c3f_pkg::column_t         col_s1
);
	c3f_pkg::rgba_t top_mem [MAX_WIDTH];
	c3f_pkg::rgba_t mid_mem [MAX_WIDTH];
	c3f_pkg::rgba_t top_rd_q, mid_rd_q, fwd_top_q, fwd_mid_q, pix_s1;
	logic [AW-1:0]  addr_s1;
	logic           fwd_q;

	assign col_s1.top = fwd_q ? fwd_top_q : top_rd_q;
	assign col_s1.mid = fwd_q ? fwd_mid_q : mid_rd_q;
	assign col_s1.bot = pix_s1;

	// Shift the column down one line at the beat's address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_mem[addr_s1] <= col_s1.mid;
			mid_mem[addr_s1] <= pix_s1;
		end
		if (rd_en) begin
			top_rd_q  <= top_mem[rd_addr];
			mid_rd_q  <= mid_mem[rd_addr];
			fwd_top_q <= col_s1.mid;
			fwd_mid_q <= pix_s1;
			pix_s1    <= pix_in;
			addr_s1   <= rd_addr;
		end
	end

	// Bypass the array when the write of this edge hits the read address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (addr_s1 == rd_addr);
		end
	end
endmodule

// ----- rtl/core/c3f_cell.sv -----
// One window column: holds three pixels, passes them on, and forms the
// masked tap products of its column for each color. Depends on c3f_pkg.
module c3f_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  c3f_pkg::cell_ctrl_t     ctrl,
	input  c3f_pkg::column_t        col_in,
	input  c3f_pkg::tap_t [2:0]     taps,
	output c3f_pkg::column_t        col_q,
	output c3f_pkg::part_t [2:0]    part_s3
);
	c3f_pkg::rgba_t rows [3];
	c3f_pkg::part_t part_d [3];

	assign rows[0] = col_q.top;
	assign rows[1] = col_q.mid;
	assign rows[2] = col_q.bot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		logic [7:0] pv;
		logic signed [c3f_pkg::PROD_W-1:0] prod;
		pv = '0;
		prod = '0;
		for (int ch = 0; ch < 3; ch++) begin
			part_d[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				// Drop neighbors outside the frame before the multiply.
				pv = (ctrl.row_ok[r] && ctrl.col_ok) ? rows[r][8*ch +: 8] : c3f_pkg::CH_MIN;
				prod = taps[r] * $signed({1'b0, pv});
				part_d[ch] = part_d[ch] + c3f_pkg::PART_W'(prod);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				part_s3[ch] <= part_d[ch];
			end
		end
	end
endmodule
